### rtl/subject_key_crc16_unit_assert.svh
// assertion macros used by the checker file
`ifndef SUBJECT_KEY_CRC16_UNIT_ASSERT_SVH
`define SUBJECT_KEY_CRC16_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet while arst_n is low
`define SKC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet while arst_n is low
`define SKC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/skc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skc_pkg
// Types, codes and the byte-wise CRC step for the subject key hash unit.
// ----------------------------------------------------------------------------
package skc_pkg;

	// item opcodes
	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_END  = 1'b1;

	// key phases
	localparam logic [1:0] PH_START  = 2'd0;
	localparam logic [1:0] PH_MATCH  = 2'd1;
	localparam logic [1:0] PH_SPACES = 2'd2;
	localparam logic [1:0] PH_BODY   = 2'd3;

	localparam logic [15:0] CRC_POLY  = 16'h1021;
	localparam logic [7:0]  CHR_SPACE = 8'h20;
	localparam logic [7:0]  CHR_UPPER_A = 8'h41;
	localparam logic [7:0]  CHR_UPPER_Z = 8'h5a;
	localparam logic [7:0]  CASE_OFFSET = 8'h20;
	localparam logic [7:0]  CHR_R     = 8'h72;
	localparam logic [7:0]  CHR_E     = 8'h65;
	localparam logic [7:0]  CHR_COLON = 8'h3a;

	// most bytes one item can push into the register ("r", "e", 0, 0)
	localparam int MAX_BYTES = 4;

	typedef struct packed {
		logic [1:0] phase;
		logic [1:0] matched;
	} skc_ctl_t;

	typedef struct packed {
		logic [2:0]           count;
		logic [MAX_BYTES-1:0][7:0] bytes;
	} skc_plan_t;

	function automatic logic [7:0] prefix_char(input logic [1:0] k);
		logic [7:0] c;
		case (k)
			2'd0: c = CHR_R;
			2'd1: c = CHR_E;
			default: c = CHR_COLON;
		endcase
		return c;
	endfunction

	// augmented crc: data bits shifted in msb first, poly applied on carry
	function automatic logic [15:0] crc_byte_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		logic        carry;
		r = crc;
		for (int i = 7; i >= 0; i--) begin
			carry = r[15];
			r = {r[14:0], b[i]};
			if (carry) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

endpackage

### rtl/subject_key_crc16_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subject_key_crc16_unit
// Subject key hash: case-folds characters, optionally strips leading "re:"
// prefixes and their spaces, and hashes the rest with an augmented CRC-16.
// ----------------------------------------------------------------------------
// One transaction on the item channel carries one key character or an end
// mark. Characters are folded to lower case; with strip_reply_prefix set on a
// key's first character, every leading "re:" and the spaces after it are
// dropped, and a partly matched prefix is hashed once the match fails. The
// surviving bytes are shifted msb first into a CRC-16 (poly 0x1021, start 0).
// An end item appends two zero bytes, emits key_crc as one transaction on the
// key channel and clears the unit for the next key. Each item sits in the
// input register while the crc update (up to four byte steps) finishes, so
// one item is taken per clock; the only stall comes from an end item whose
// result register is still held by a stalled key channel. A character
// item in the input register never waits on the key channel.
// ----------------------------------------------------------------------------
module subject_key_crc16_unit
	import skc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        op,
	input  logic [7:0]  char_code,
	input  logic        strip_reply_prefix,
	// key channel
	output logic        key_valid,
	input  logic        key_stall,
	output logic [15:0] key_crc
);

	// input register
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] char_s1;
	logic       strip_s1;

	// key state
	skc_ctl_t    ctl_q;
	logic [15:0] crc_q;

	// result register
	logic        key_valid_q;
	logic [15:0] key_crc_q;

	skc_ctl_t    ctl_next;
	skc_plan_t   plan;
	logic [15:0] crc_next;
	logic        advance;
	logic        item_take;

	// an end item moves on only when the result register is free or leaving
	assign advance    = valid_s1 && (op_s1 == OP_CHAR || !key_valid_q || !key_stall);
	assign item_stall = valid_s1 && !advance;
	assign item_take  = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			op_s1    <= op;
			char_s1  <= char_code;
			strip_s1 <= strip_reply_prefix;
		end
	end

	skc_plan u_plan (
		.ctl                (ctl_q),
		.op                 (op_s1),
		.char_code          (char_s1),
		.strip_reply_prefix (strip_s1),
		.ctl_next           (ctl_next),
		.plan               (plan)
	);

	skc_crc u_crc (
		.crc      (crc_q),
		.plan     (plan),
		.crc_next (crc_next)
	);

	// key state: end items return everything to the start of a key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
			crc_q <= '0;
		end else if (advance) begin
			ctl_q <= ctl_next;
			crc_q <= (op_s1 == OP_END) ? 16'h0000 : crc_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_valid_q <= 1'b0;
		end else if (advance && op_s1 == OP_END) begin
			key_valid_q <= 1'b1;
		end else if (!key_stall) begin
			key_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && op_s1 == OP_END) begin
			key_crc_q <= crc_next;
		end
	end

	assign key_valid = key_valid_q;
	assign key_crc   = key_crc_q;

endmodule

### rtl/skc_plan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skc_plan
// Prefix matcher: decides which bytes one item feeds into the crc and the
// next key phase.
// ----------------------------------------------------------------------------
module skc_plan
	import skc_pkg::*;
(
	input  skc_ctl_t   ctl,
	input  logic       op,
	input  logic [7:0] char_code,
	input  logic       strip_reply_prefix,
	output skc_ctl_t   ctl_next,
	output skc_plan_t  plan
);

	logic [7:0] lc;
	logic [7:0] tail;
	logic [1:0] held;
	logic [1:0] n_tail;
	logic       match_en;
	logic [1:0] match_k;

	assign lc = (char_code >= CHR_UPPER_A && char_code <= CHR_UPPER_Z) ?
		char_code + CASE_OFFSET : char_code;

	always_comb begin
		ctl_next = ctl;
		held     = 2'd0;
		n_tail   = 2'd0;
		tail     = lc;
		match_en = 1'b0;
		match_k  = 2'd0;
		if (op == OP_END) begin
			// held prefix characters go in before the two zero bytes
			if (ctl.phase == PH_MATCH) begin
				held = (ctl.matched == 2'd3) ? 2'd2 : ctl.matched;
			end
			tail     = 8'h00;
			n_tail   = 2'd2;
			ctl_next = '0;
		end else begin
			case (ctl.phase)
				PH_START: begin
					if (strip_reply_prefix) begin
						match_en = 1'b1;
					end else begin
						n_tail         = 2'd1;
						ctl_next.phase = PH_BODY;
					end
				end
				PH_MATCH: begin
					match_en = 1'b1;
					match_k  = ctl.matched;
				end
				PH_SPACES: begin
					if (lc != CHR_SPACE) begin
						match_en = 1'b1;
					end
				end
				default: begin
					n_tail = 2'd1;
				end
			endcase
			if (match_en) begin
				if (match_k != 2'd3 && lc == prefix_char(match_k)) begin
					if (match_k == 2'd2) begin
						ctl_next = '{phase: PH_SPACES, matched: 2'd0};
					end else begin
						ctl_next = '{phase: PH_MATCH, matched: match_k + 2'd1};
					end
				end else begin
					held     = (match_k == 2'd3) ? 2'd2 : match_k;
					n_tail   = 2'd1;
					ctl_next = '{phase: PH_BODY, matched: 2'd0};
				end
			end
		end
	end

	always_comb begin
		plan.count = {1'b0, held} + {1'b0, n_tail};
		for (int i = 0; i < MAX_BYTES; i++) begin
			plan.bytes[i] = (i < int'(held)) ? prefix_char(2'(i)) : tail;
		end
	end

endmodule

### rtl/skc_crc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skc_crc
// Combinationally feeds up to four planned bytes through the crc register.
// ----------------------------------------------------------------------------
module skc_crc
	import skc_pkg::*;
(
	input  logic [15:0] crc,
	input  skc_plan_t   plan,
	output logic [15:0] crc_next
);

	logic [MAX_BYTES:0][15:0] chain;

	always_comb begin
		chain[0] = crc;
		for (int i = 0; i < MAX_BYTES; i++) begin
			chain[i+1] = crc_byte_step(chain[i], plan.bytes[i]);
		end
		crc_next = chain[MAX_BYTES];
		case (plan.count)
			3'd0: crc_next = chain[0];
			3'd1: crc_next = chain[1];
			3'd2: crc_next = chain[2];
			3'd3: crc_next = chain[3];
			default: crc_next = chain[MAX_BYTES];
		endcase
	end

endmodule

### rtl/skc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skc_checker
// Port-level checks for the subject key hash unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "subject_key_crc16_unit_assert.svh"

module skc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_stall,
	input logic        key_valid,
	input logic        key_stall,
	input logic [15:0] key_crc
);

	// a stalled key transaction keeps its value
	`SKC_ASSERT_NXT(a_key_hold, key_valid && key_stall, key_valid && $stable(key_crc), "key_crc changed while stalled")

	// back-pressure on items only arises from a held, stalled result
	`SKC_ASSERT_IMP(a_stall_cause, item_stall, key_valid && key_stall, "item stall without a stalled key")

	// a free key channel never holds up the item side
	`SKC_ASSERT_IMP(a_no_idle_stall, !key_stall, !item_stall, "item stall while key channel is free")

endmodule

bind subject_key_crc16_unit skc_checker u_skc_checker (.*);
